FILE: hw/rtl/gradient_orientation_histogram_macros.svh
// Assertion macros used by the orientation histogram back end
`ifndef GRADIENT_ORIENTATION_HISTOGRAM_MACROS_SVH
`define GRADIENT_ORIENTATION_HISTOGRAM_MACROS_SVH

// Property must hold at every rising clock edge outside reset
`define GOH_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("histogram assertion failed");

// Condition must never be seen outside reset
`define GOH_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("histogram forbidden condition seen");

`endif

FILE: hw/rtl/goh_pkg.sv
// Shared types, constants and tables of the orientation histogram
package goh_pkg;

    localparam int NUM_BINS     = 36;
    localparam int BIN_W        = $clog2(NUM_BINS);
    localparam int VAL_W        = 40;
    localparam int PIX_W        = 16;
    localparam int OFF_W        = 6;
    localparam int DIF_W        = PIX_W + 1;
    localparam int D2_W         = 11;
    localparam int SCL_W        = 16;
    localparam int OUT_IDX_W    = 6;

    // Configuration port
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DAT_W    = 16;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_ROW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_COL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RAD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_SCALE = 3'd5;

    // Queue between front and back
    localparam int QDEPTH       = 2;
    localparam int QPTR_W       = $clog2(QDEPTH);
    localparam int QCNT_W       = $clog2(QDEPTH + 1);

    // Angle, bin division
    localparam int ANG_W        = 25;
    localparam int QW           = $clog2(NUM_BINS + 1);
    localparam int NUM_W        = ANG_W + QW;
    localparam logic [NUM_W-1:0] HALF_OFS = NUM_W'(180 * 65536);
    // Numerator is divided by 2^16 first, then by 360 through a reciprocal;
    // ceil(2^23/360) is exact for quotients of values below 2^23/112
    localparam int DIV_SH       = 23;
    localparam int QV_W         = NUM_W - 16;
    localparam logic [QV_W-1:0] RECIP_360 = QV_W'((1 << DIV_SH) / 360 + 1);

    // Magnitude and rotation datapath
    localparam int SQ_W         = 2 * PIX_W + 1;
    localparam int RT_W         = SQ_W + 1;
    localparam int MAG_W        = PIX_W + 1;
    localparam int XW           = 37;
    localparam int ZW           = 27;
    localparam logic signed [ZW-1:0] DEG360 = ZW'(360 * 65536);
    localparam logic signed [ZW-1:0] DEG180 = ZW'(180 * 65536);
    localparam int CORDIC_STEPS = 16;
    localparam int ISQRT_STEPS  = 17;

    // Weight and accumulation
    localparam int T_W          = D2_W + SCL_W;
    localparam int P_W          = 18;
    localparam int W_W          = 17;
    localparam int ADD_W        = MAG_W + W_W;
    localparam int SUM_W        = VAL_W + 5;
    localparam int EXP_INT_N    = 12;

    // Sequencer counter
    localparam int CNT_MAX      = (NUM_BINS + 6 > ISQRT_STEPS) ? NUM_BINS + 6 : ISQRT_STEPS;
    localparam int CNT_W        = $clog2(CNT_MAX + 1);

    typedef struct packed {
        logic                    keep;
        logic                    last;
        logic signed [DIF_W-1:0] dx;
        logic signed [DIF_W-1:0] dy;
        logic [D2_W-1:0]         d2;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef enum logic [3:0] {
        B_IDLE, B_SQ, B_ITER, B_ANG, B_NUM, B_DIV, B_RD, B_WR, B_SMOOTH, B_EMIT
    } t_bstate;

    // Rotation angles in degrees, Q16
    function automatic logic signed [ZW-1:0] atan_q16(input logic [3:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            4'd0:    v = ZW'(2949120);
            4'd1:    v = ZW'(1740967);
            4'd2:    v = ZW'(919879);
            4'd3:    v = ZW'(466945);
            4'd4:    v = ZW'(234379);
            4'd5:    v = ZW'(117304);
            4'd6:    v = ZW'(58666);
            4'd7:    v = ZW'(29335);
            4'd8:    v = ZW'(14668);
            4'd9:    v = ZW'(7334);
            4'd10:   v = ZW'(3667);
            4'd11:   v = ZW'(1833);
            4'd12:   v = ZW'(917);
            4'd13:   v = ZW'(458);
            4'd14:   v = ZW'(229);
            4'd15:   v = ZW'(115);
            default: v = '0;
        endcase
        return v;
    endfunction

    // exp of minus integer part, Q16
    function automatic logic [W_W-1:0] exp_int(input logic [3:0] k);
        logic [W_W-1:0] v;
        case (k)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd24109;
            4'd2:    v = 17'd8869;
            4'd3:    v = 17'd3263;
            4'd4:    v = 17'd1200;
            4'd5:    v = 17'd442;
            4'd6:    v = 17'd162;
            4'd7:    v = 17'd60;
            4'd8:    v = 17'd22;
            4'd9:    v = 17'd8;
            4'd10:   v = 17'd3;
            4'd11:   v = 17'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // exp of minus sixteenths, Q16
    function automatic logic [W_W-1:0] exp_frac(input logic [3:0] m);
        logic [W_W-1:0] v;
        case (m)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd61565;
            4'd2:    v = 17'd57835;
            4'd3:    v = 17'd54331;
            4'd4:    v = 17'd51039;
            4'd5:    v = 17'd47947;
            4'd6:    v = 17'd45042;
            4'd7:    v = 17'd42313;
            4'd8:    v = 17'd39750;
            4'd9:    v = 17'd37341;
            4'd10:   v = 17'd35079;
            4'd11:   v = 17'd32954;
            4'd12:   v = 17'd30957;
            4'd13:   v = 17'd29081;
            4'd14:   v = 17'd27319;
            4'd15:   v = 17'd25664;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: hw/rtl/goh_front.sv
// Front end: configuration registers, item accept, border and radius test, gradient
module goh_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [goh_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [goh_pkg::CFG_DAT_W-1:0]       i_cfg_data,
    input  logic                                i_start,
    input  logic signed [goh_pkg::OFF_W-1:0]    i_row_offset,
    input  logic signed [goh_pkg::OFF_W-1:0]    i_col_offset,
    input  logic [goh_pkg::PIX_W-1:0]           i_pixel_right,
    input  logic [goh_pkg::PIX_W-1:0]           i_pixel_left,
    input  logic [goh_pkg::PIX_W-1:0]           i_pixel_up,
    input  logic [goh_pkg::PIX_W-1:0]           i_pixel_down,
    input  logic                                i_window_end,
    input  goh_pkg::t_qstat                     i_qstat,
    output logic                                o_busy,
    output logic                                o_push,
    output goh_pkg::t_item                      o_item,
    output logic [goh_pkg::SCL_W-1:0]           o_scale
);
    import goh_pkg::*;

    logic [11:0]      r_center_row;
    logic [11:0]      r_center_col;
    logic [12:0]      r_image_rows;
    logic [12:0]      r_image_cols;
    logic [4:0]       r_radius;
    logic [SCL_W-1:0] r_scale;

    logic signed [13:0] row_pos, col_pos, row_lim, col_lim;
    logic [OFF_W-1:0]   ar, ac;
    logic [9:0]         ar_sq, ac_sq;
    logic               in_window;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_row <= '0;
            r_center_col <= '0;
            r_image_rows <= '0;
            r_image_cols <= '0;
            r_radius     <= 5'd1;
            r_scale      <= 16'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_CENTER_ROW:   r_center_row <= i_cfg_data[11:0];
                REG_CENTER_COL:   r_center_col <= i_cfg_data[11:0];
                REG_IMAGE_ROWS:   r_image_rows <= i_cfg_data[12:0];
                REG_IMAGE_COLS:   r_image_cols <= i_cfg_data[12:0];
                REG_WINDOW_RAD:   r_radius     <= i_cfg_data[4:0];
                REG_WEIGHT_SCALE: r_scale      <= i_cfg_data[SCL_W-1:0];
                default: ;
            endcase
        end
    end

    // Classify the sample: border, radius, squared offset
    always_comb begin
        row_pos = $signed({2'b00, r_center_row}) + 14'(i_row_offset);
        col_pos = $signed({2'b00, r_center_col}) + 14'(i_col_offset);
        row_lim = $signed({1'b0, r_image_rows}) - 14'sd1;
        col_lim = $signed({1'b0, r_image_cols}) - 14'sd1;
        ar      = i_row_offset[OFF_W-1] ? OFF_W'(-i_row_offset) : i_row_offset;
        ac      = i_col_offset[OFF_W-1] ? OFF_W'(-i_col_offset) : i_col_offset;
        ar_sq   = ar[4:0] * ar[4:0];
        ac_sq   = ac[4:0] * ac[4:0];
        in_window = (row_pos > 14'sd0) && (row_pos < row_lim) &&
                    (col_pos > 14'sd0) && (col_pos < col_lim) &&
                    (ar <= {1'b0, r_radius}) && (ac <= {1'b0, r_radius});
    end

    // Build the queued item
    always_comb begin
        o_item.keep = in_window;
        o_item.last = i_window_end;
        o_item.dx   = $signed({1'b0, i_pixel_right}) - $signed({1'b0, i_pixel_left});
        o_item.dy   = $signed({1'b0, i_pixel_up}) - $signed({1'b0, i_pixel_down});
        o_item.d2   = {1'b0, ar_sq} + {1'b0, ac_sq};
    end

    assign o_busy  = i_qstat.full || !i_rst_n;
    assign o_push  = i_start && !o_busy;
    assign o_scale = r_scale;

endmodule

FILE: hw/rtl/goh_queue.sv
// Short item queue between front and back
module goh_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  goh_pkg::t_item i_item,
    input  logic           i_pop,
    output goh_pkg::t_item o_item,
    output goh_pkg::t_qstat o_qstat
);
    import goh_pkg::*;

    t_item              r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wp, r_rp;
    logic [QCNT_W-1:0]  r_cnt;
    logic               do_push, do_pop;

    assign do_push = i_push && (r_cnt != QCNT_W'(QDEPTH));
    assign do_pop  = i_pop && (r_cnt != '0);

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= (r_wp == QPTR_W'(QDEPTH-1)) ? '0 : r_wp + 1'b1;
            if (do_pop)  r_rp <= (r_rp == QPTR_W'(QDEPTH-1)) ? '0 : r_rp + 1'b1;
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: ;
            endcase
        end
    end

    // Hold entries
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_item;
    end

    assign o_item        = r_mem[r_rp];
    assign o_qstat.full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_qstat.empty = (r_cnt == '0);

endmodule

FILE: hw/rtl/goh_back.sv
// Back end: magnitude, angle, weight, bin update, smoothing and emission
`include "gradient_orientation_histogram_macros.svh"
module goh_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  goh_pkg::t_qstat                    i_qstat,
    input  goh_pkg::t_item                     i_item,
    input  logic [goh_pkg::SCL_W-1:0]          i_scale,
    output logic                               o_pop,
    output logic                               o_bin_valid,
    output logic [goh_pkg::OUT_IDX_W-1:0]      o_bin_index,
    output logic [goh_pkg::VAL_W-1:0]          o_bin_value,
    output logic [goh_pkg::VAL_W-1:0]          o_peak_value,
    output logic                               o_final_bin
);
    import goh_pkg::*;

    t_bstate r_state, n_state;
    logic [CNT_W-1:0] r_cnt;

    // Item and datapath registers
    t_item                 r_item;
    logic [RT_W-1:0]       r_rem, r_res;
    logic signed [XW-1:0]  r_x, r_y;
    logic signed [ZW-1:0]  r_z;
    logic [T_W-1:0]        r_t;
    logic [P_W-1:0]        r_p;
    logic [W_W-1:0]        r_w;
    logic [ANG_W-1:0]      r_ang;
    logic [ADD_W-1:0]      r_add;
    logic [NUM_W-1:0]      r_num;
    logic [QW-1:0]         r_q;
    logic [VAL_W-1:0]      r_peak;
    logic [VAL_W-1:0]      r_tap [5];
    logic [BIN_W-1:0]      r_saddr, r_widx;
    logic [VAL_W-1:0]      r_rdata, r_srdata;
    logic                  r_emit_vld, r_final;
    logic [BIN_W-1:0]      r_eidx;

    // Stores
    logic [VAL_W-1:0]      r_acc [NUM_BINS];
    logic [NUM_BINS-1:0]   r_acc_vld;
    logic [VAL_W-1:0]      r_sm  [NUM_BINS];

    // Memory controls
    logic                  acc_rd, acc_we, sm_we;
    logic [BIN_W-1:0]      acc_raddr, acc_waddr;
    logic [VAL_W-1:0]      acc_wdata;

    // Combinational helpers
    logic [5:0]            sq_sh;
    logic [RT_W-1:0]       sq_bit, sq_trial;
    logic signed [XW-1:0]  xs, ys;
    logic [BIN_W-1:0]      bin_w;
    logic [VAL_W:0]        acc_sum;
    logic [VAL_W-1:0]      acc_sat;
    logic [SUM_W-1:0]      sm_sum;
    logic [VAL_W:0]        sm_div;
    logic [VAL_W-1:0]      sm_val;
    logic [2*QV_W-1:0]     div_prod;
    logic [10:0]           wk;
    logic signed [2*DIF_W-1:0] dxx, dyy;
    logic signed [XW-1:0]  x_init, y_init;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (!i_qstat.empty) begin
                    if (i_item.keep)      n_state = B_SQ;
                    else if (i_item.last) n_state = B_SMOOTH;
                end
            end
            B_SQ:   n_state = B_ITER;
            B_ITER: if (r_cnt == CNT_W'(ISQRT_STEPS-1)) n_state = B_ANG;
            B_ANG:  n_state = B_NUM;
            B_NUM:  n_state = B_DIV;
            B_DIV:  n_state = B_RD;
            B_RD:   n_state = B_WR;
            B_WR:   n_state = r_item.last ? B_SMOOTH : B_IDLE;
            B_SMOOTH: if (r_cnt == CNT_W'(NUM_BINS+5)) n_state = B_EMIT;
            B_EMIT: if (r_cnt == CNT_W'(NUM_BINS-1)) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    // Arithmetic helpers
    always_comb begin
        sq_sh    = {5'(ISQRT_STEPS-1) - r_cnt[4:0], 1'b0};
        sq_bit   = RT_W'(1) << sq_sh;
        sq_trial = r_res + sq_bit;
        xs       = r_x >>> r_cnt[3:0];
        ys       = r_y >>> r_cnt[3:0];
        bin_w    = (r_q == QW'(NUM_BINS)) ? '0 : BIN_W'(r_q);
        acc_sum  = {1'b0, r_rdata} + (VAL_W+1)'(r_add);
        acc_sat  = acc_sum[VAL_W] ? '1 : acc_sum[VAL_W-1:0];
        sm_sum   = SUM_W'(r_tap[0]) + SUM_W'(r_tap[4])
                 + ((SUM_W'(r_tap[1]) + SUM_W'(r_tap[3])) << 2)
                 + (SUM_W'(r_tap[2]) << 2) + (SUM_W'(r_tap[2]) << 1);
        sm_div   = (VAL_W+1)'((sm_sum + SUM_W'(8)) >> 4);
        sm_val   = sm_div[VAL_W] ? '1 : sm_div[VAL_W-1:0];
        div_prod = (2*QV_W)'(r_num[NUM_W-1:16]) * (2*QV_W)'(RECIP_360);
        wk       = r_t[T_W-1:16];
        dxx      = r_item.dx * r_item.dx;
        dyy      = r_item.dy * r_item.dy;
        x_init   = XW'(r_item.dx) <<< 16;
        y_init   = XW'(r_item.dy) <<< 16;
    end

    // Outputs of the sequencer: pop and memory controls
    always_comb begin
        o_pop     = 1'b0;
        acc_rd    = 1'b0;
        acc_raddr = '0;
        acc_we    = 1'b0;
        acc_waddr = '0;
        acc_wdata = '0;
        sm_we     = 1'b0;
        case (r_state)
            B_IDLE: o_pop = !i_qstat.empty;
            B_RD: begin
                acc_rd    = 1'b1;
                acc_raddr = bin_w;
            end
            B_WR: begin
                acc_we    = 1'b1;
                acc_waddr = bin_w;
                acc_wdata = acc_sat;
            end
            B_SMOOTH: begin
                acc_rd    = (r_cnt < CNT_W'(NUM_BINS+4));
                acc_raddr = r_saddr;
                sm_we     = (r_cnt >= CNT_W'(6));
            end
            B_EMIT: begin
                acc_we    = 1'b1;
                acc_waddr = BIN_W'(r_cnt);
                acc_wdata = '0;
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= B_IDLE;
            r_cnt      <= '0;
            r_emit_vld <= 1'b0;
            r_final    <= 1'b0;
            r_acc_vld  <= '0;
        end else begin
            r_state <= n_state;
            if (n_state != r_state)
                r_cnt <= '0;
            else if (r_state == B_IDLE)
                r_cnt <= '0;
            else
                r_cnt <= r_cnt + 1'b1;
            r_emit_vld <= (r_state == B_EMIT);
            r_final    <= (r_state == B_EMIT) && (r_cnt == CNT_W'(NUM_BINS-1));
            if (acc_we) r_acc_vld[acc_waddr] <= 1'b1;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: if (o_pop) r_item <= i_item;
            B_SQ: begin
                r_rem <= RT_W'(dxx) + RT_W'(dyy);
                r_res <= '0;
                if (r_item.dx < 0) begin
                    r_x <= -x_init;
                    r_y <= -y_init;
                    r_z <= DEG180;
                end else begin
                    r_x <= x_init;
                    r_y <= y_init;
                    r_z <= '0;
                end
            end
            B_ITER: begin
                // one root digit
                if (r_rem >= sq_trial) begin
                    r_rem <= r_rem - sq_trial;
                    r_res <= (r_res >> 1) + sq_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                // one rotation step
                if (r_cnt < CNT_W'(CORDIC_STEPS)) begin
                    if (r_y >= 0) begin
                        r_x <= r_x + ys;
                        r_y <= r_y - xs;
                        r_z <= r_z + atan_q16(r_cnt[3:0]);
                    end else begin
                        r_x <= r_x - ys;
                        r_y <= r_y + xs;
                        r_z <= r_z - atan_q16(r_cnt[3:0]);
                    end
                end
                // weight pipeline settles while the loop runs
                r_t <= T_W'(r_item.d2) * T_W'(i_scale);
                r_p <= (wk < 11'(EXP_INT_N))
                     ? P_W'((34'(exp_int(wk[3:0])) * 34'(exp_frac(r_t[15:12]))) >> 16)
                     : '0;
                r_w <= W_W'((35'(r_p) * 35'(17'h10000 - {5'b0, r_t[11:0]})) >> 16);
            end
            B_ANG: begin
                if (r_z < 0)
                    r_ang <= ANG_W'(r_z + DEG360);
                else if (r_z >= DEG360)
                    r_ang <= ANG_W'(r_z - DEG360);
                else
                    r_ang <= ANG_W'(r_z);
                r_add <= ADD_W'(r_res[MAG_W-1:0]) * ADD_W'(r_w);
            end
            B_NUM: begin
                r_num <= NUM_W'(r_ang) * NUM_W'(NUM_BINS) + HALF_OFS;
                r_q   <= '0;
            end
            B_DIV: begin
                // bin number by reciprocal multiplication
                r_q <= QW'(div_prod >> DIV_SH);
            end
            default: ;
        endcase

        // smoothing window and peak
        if (r_state != B_SMOOTH) begin
            r_saddr <= BIN_W'(NUM_BINS-2);
            r_widx  <= '0;
        end else begin
            if (acc_rd) r_saddr <= (r_saddr == BIN_W'(NUM_BINS-1)) ? '0 : r_saddr + 1'b1;
            if (sm_we)  r_widx  <= r_widx + 1'b1;
            r_tap[0] <= r_tap[1];
            r_tap[1] <= r_tap[2];
            r_tap[2] <= r_tap[3];
            r_tap[3] <= r_tap[4];
            r_tap[4] <= r_rdata;
        end
        if (n_state == B_SMOOTH && r_state != B_SMOOTH)
            r_peak <= '0;
        else if (sm_we && sm_val > r_peak)
            r_peak <= sm_val;

        r_eidx <= BIN_W'(r_cnt);
    end

    // Bin store
    always_ff @(posedge i_clk) begin
        if (acc_we) r_acc[acc_waddr] <= acc_wdata;
        if (acc_rd) r_rdata <= r_acc_vld[acc_raddr] ? r_acc[acc_raddr] : '0;
    end

    // Smoothed store
    always_ff @(posedge i_clk) begin
        if (sm_we) r_sm[r_widx] <= sm_val;
        if (r_state == B_EMIT) r_srdata <= r_sm[BIN_W'(r_cnt)];
    end

    assign o_bin_valid  = r_emit_vld;
    assign o_bin_index  = OUT_IDX_W'(r_eidx);
    assign o_bin_value  = r_srdata;
    assign o_peak_value = r_peak;
    assign o_final_bin  = r_final;

    `GOH_ASSERT(a_bin_range, i_clk, i_rst_n, (r_state == B_RD) |-> (r_q <= QW'(NUM_BINS)))
    `GOH_ASSERT(a_final_last, i_clk, i_rst_n, o_final_bin |-> (o_bin_valid && (r_eidx == BIN_W'(NUM_BINS-1))))
    `GOH_ASSERT_NEVER(a_no_wr_smooth, i_clk, i_rst_n, (r_state == B_SMOOTH) && acc_we)
    `GOH_ASSERT(a_emit_follows, i_clk, i_rst_n, $rose(o_bin_valid) |-> (o_bin_index == '0))

endmodule

FILE: hw/rtl/gradient_orientation_histogram.sv
// A kept sample holds the back end through pop, square, a 17-step loop, angle wrap,
// numerator, divide, read and write; a skipped sample is only popped in the idle state.
// A window end adds a pass of circular smoothing, then NUM_BINS results on
// consecutive cycles with no back pressure. A two-entry queue lets the front accept
// while the back works. Reset is synchronous, active low; it clears the bins and state.
module gradient_orientation_histogram (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [goh_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [goh_pkg::CFG_DAT_W-1:0]       i_cfg_data,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [goh_pkg::OFF_W-1:0]    i_row_offset,
    input  logic signed [goh_pkg::OFF_W-1:0]    i_col_offset,
    input  logic [goh_pkg::PIX_W-1:0]           i_pixel_right,
    input  logic [goh_pkg::PIX_W-1:0]           i_pixel_left,
    input  logic [goh_pkg::PIX_W-1:0]           i_pixel_up,
    input  logic [goh_pkg::PIX_W-1:0]           i_pixel_down,
    input  logic                                i_window_end,
    output logic                                o_bin_valid,
    output logic [goh_pkg::OUT_IDX_W-1:0]       o_bin_index,
    output logic [goh_pkg::VAL_W-1:0]           o_bin_value,
    output logic [goh_pkg::VAL_W-1:0]           o_peak_value,
    output logic                                o_final_bin
);
    import goh_pkg::*;

    t_item            f_item, q_item;
    t_qstat           qstat;
    logic             push, pop;
    logic [SCL_W-1:0] scale;

    // Accept and classify items
    goh_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_start       (start),
        .i_row_offset  (i_row_offset),
        .i_col_offset  (i_col_offset),
        .i_pixel_right (i_pixel_right),
        .i_pixel_left  (i_pixel_left),
        .i_pixel_up    (i_pixel_up),
        .i_pixel_down  (i_pixel_down),
        .i_window_end  (i_window_end),
        .i_qstat       (qstat),
        .o_busy        (busy),
        .o_push        (push),
        .o_item        (f_item),
        .o_scale       (scale)
    );

    // Buffer classified items
    goh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .i_pop   (pop),
        .o_item  (q_item),
        .o_qstat (qstat)
    );

    // Update, smooth and emit the histogram
    goh_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_qstat      (qstat),
        .i_item       (q_item),
        .i_scale      (scale),
        .o_pop        (pop),
        .o_bin_valid  (o_bin_valid),
        .o_bin_index  (o_bin_index),
        .o_bin_value  (o_bin_value),
        .o_peak_value (o_peak_value),
        .o_final_bin  (o_final_bin)
    );

endmodule
